>>> hdl/bmc_pkg.sv
// Shared types and constants of the bit mask crusher.
// No dependencies; used by the top level, front end and back end.
package bmc_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int FactorW  = 7;
  localparam int CountW   = 6;
  localparam int MaskW    = 8;
  localparam int GainW    = 16;
  localparam int ThrW     = 15;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FACTOR = 3'd0,
    CFG_KEEP   = 3'd1,
    CFG_INVERT = 3'd2,
    CFG_DRY    = 3'd3,
    CFG_WET    = 3'd4,
    CFG_GATE   = 3'd5
  } cfg_reg_e;

  localparam logic [FactorW-1:0] FactorRst = 7'd1;
  localparam logic [MaskW-1:0]   KeepRst   = 8'd255;
  localparam logic [MaskW-1:0]   InvertRst = 8'd0;
  localparam logic [GainW-1:0]   DryRst    = 16'd32768;
  localparam logic [GainW-1:0]   WetRst    = 16'd0;
  localparam logic [ThrW-1:0]    GateRst   = 15'd328;

  // Crusher and mix settings seen by the back end.
  typedef struct packed {
    logic [MaskW-1:0] keep_mask;
    logic [MaskW-1:0] invert_mask;
    logic [GainW-1:0] dry_gain;
    logic [GainW-1:0] wet_gain;
    logic [ThrW-1:0]  gate_threshold;
  } cfg_t;

endpackage

>>> hdl/bmc_fifo.sv
// Small register queue between front end and back end.
// No dependencies.
module bmc_fifo #(
  parameter int Width = 32,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hdl/bmc_front.sv
// Front end: accepts samples, runs per-channel sample-and-hold, queues work.
// Depends on bmc_pkg.
module bmc_front #(
  parameter int SampleBits = 16,
  parameter int Channels   = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              channel_i,
  input  logic signed [SampleBits-1:0]      sample_in_i,
  input  logic [bmc_pkg::FactorW-1:0]       factor_i,
  output logic                              push_o,
  output logic [2*SampleBits-1:0]           push_data_o,
  input  logic                              full_i
);

  localparam int ChW = (Channels > 1) ? $clog2(Channels) : 1;

  logic [SampleBits-1:0]          held_q  [Channels];
  logic [bmc_pkg::CountW-1:0]     count_q [Channels];
  logic [ChW-1:0]                 idx;
  logic                           accept;
  logic                           capture;
  logic [bmc_pkg::FactorW-1:0]    factor_eff;
  logic [bmc_pkg::CountW-1:0]     reload;
  logic [SampleBits-1:0]          held_new;

  assign idx        = (Channels > 1) ? ChW'(channel_i) : '0;
  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;
  assign capture    = (count_q[idx] == '0);

  // Clamp the factor to 1..64.
  always_comb begin
    if (factor_i == '0) begin
      factor_eff = bmc_pkg::FactorW'(1);
    end else if (factor_i > bmc_pkg::FactorW'(64)) begin
      factor_eff = bmc_pkg::FactorW'(64);
    end else begin
      factor_eff = factor_i;
    end
  end

  assign reload      = bmc_pkg::CountW'(factor_eff - 1'b1);
  assign held_new    = capture ? sample_in_i : held_q[idx];
  assign push_data_o = {sample_in_i, held_new};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Channels; i++) begin
        held_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else if (accept) begin
      held_q[idx]  <= held_new;
      count_q[idx] <= capture ? reload : count_q[idx] - 1'b1;
    end
  end

endmodule

>>> hdl/bmc_back.sv
// Back end: crushes the held sample and mixes it with the dry input,
// sequenced over one shared multiplier. Depends on bmc_pkg.
module bmc_back #(
  parameter int QuantBits  = 8,
  parameter int SampleBits = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bmc_pkg::cfg_t                cfg_i,
  input  logic                         q_valid_i,
  input  logic [2*SampleBits-1:0]      q_data_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [SampleBits-1:0] sample_out_o
);

  localparam int S     = SampleBits;
  localparam int QB    = QuantBits;
  localparam longint QMax  = (64'd1 << QB) - 64'd1;
  localparam longint Half  = QMax >> 1;
  localparam int P     = S + QB - 1;
  localparam longint Recip = (64'd1 << P) / QMax;
  localparam longint HalfR = Half * Recip;
  localparam int AW    = bmc_pkg::GainW;
  localparam int BW    = S + 2;
  localparam int PW    = AW + 1 + BW;
  localparam int MW    = PW + 1;
  localparam int SW    = QB + 2 * S + 1;
  localparam int NW    = QB + S;

  typedef enum logic [2:0] {
    ST_QUANT,
    ST_RECIP,
    ST_EST,
    ST_CORR,
    ST_WET,
    ST_OUT
  } state_e;

  state_e                  state_q;
  logic signed [S-1:0]     held_q;
  logic                    neg_q, gated_q, bypass_q;
  logic [QB-1:0]           q2_q;
  logic signed [PW-1:0]    prod_q, acc_q;
  logic [S-1:0]            est_q;
  logic signed [S:0]       crushed_q;
  logic                    out_valid_q;
  logic signed [S-1:0]     sample_out_q;

  // Quantizer on the queue head
  logic signed [S-1:0]     x_in, held_in;
  logic [S-1:0]            mag;
  logic [S+13:0]           thr_ext;
  logic [S-2:0]            level;
  logic [15:0]             keep16, inv16;
  logic [QB-1:0]           keep, inv, q, q2;
  logic [S+QB-1:0]         qt;
  logic                    gated, bypass;

  assign x_in    = q_data_i[2*S-1:S];
  assign held_in = q_data_i[S-1:0];
  assign mag     = held_in[S-1] ? (~held_in + 1'b1) : held_in;
  assign thr_ext = {cfg_i.gate_threshold, {(S-1){1'b0}}};
  assign level   = thr_ext[S+13:15];
  assign gated   = (mag < {1'b0, level}) || (mag == '0);
  assign keep16  = {8'hFF, cfg_i.keep_mask};
  assign inv16   = {8'h00, cfg_i.invert_mask};
  assign keep    = keep16[QB-1:0];
  assign inv     = inv16[QB-1:0];
  assign bypass  = (&keep) && (inv == '0);
  assign qt      = {mag, {QB{1'b0}}} - {{QB{1'b0}}, mag} + ((S+QB)'(1) << (S-2));
  assign q       = qt[S+QB-2:S-1];
  assign q2      = (q & keep) ^ inv;

  // Shared multiplier, operands picked by state
  logic [AW-1:0]           mul_a;
  logic signed [BW-1:0]    mul_b;
  logic signed [PW-1:0]    prod_d;

  always_comb begin
    unique case (state_q)
      ST_QUANT: begin
        mul_a = cfg_i.dry_gain;
        mul_b = {{2{x_in[S-1]}}, x_in};
      end
      ST_RECIP: begin
        mul_a = AW'(q2_q);
        mul_b = $signed({1'b0, Recip[S:0]});
      end
      default: begin
        mul_a = cfg_i.wet_gain;
        mul_b = {crushed_q[S], crushed_q};
      end
    endcase
  end

  assign prod_d = $signed({1'b0, mul_a}) * mul_b;

  // Reciprocal estimate of the rescale division, low by at most one
  logic [QB+S:0]           pr;
  logic [SW-1:0]           est_sum;
  logic [S-1:0]            est_d;

  assign pr      = prod_q[QB+S:0];
  assign est_sum = SW'({pr, {(S-1){1'b0}}}) + SW'(HalfR);
  assign est_d   = S'(est_sum >> P);

  // Correct the estimate and restore the sign
  logic [NW-1:0]           num, est_x, rem;
  logic [S-1:0]            m;
  logic signed [S:0]       m_s, crushed_d;

  assign num   = {q2_q, {(S-1){1'b0}}} + NW'(Half);
  assign est_x = {est_q, {QB{1'b0}}} - NW'(est_q);
  assign rem   = num - est_x;
  assign m     = est_q + S'(rem >= NW'(QMax));
  assign m_s   = $signed({1'b0, m});

  always_comb begin
    priority if (bypass_q) begin
      crushed_d = {held_q[S-1], held_q};
    end else if (gated_q) begin
      crushed_d = '0;
    end else if (neg_q) begin
      crushed_d = -m_s;
    end else begin
      crushed_d = m_s;
    end
  end

  // Final mix, round half up, saturate
  logic signed [MW-1:0]    mix;
  logic signed [MW-16:0]   y;
  logic signed [S-1:0]     y_sat;
  localparam logic signed [MW-16:0] YMax = (MW-15)'((64'd1 << (S-1)) - 64'd1);
  localparam logic signed [MW-16:0] YMin = -(MW-15)'(64'd1 << (S-1));

  assign mix = MW'(acc_q) + MW'(prod_q) + MW'(16384);
  assign y   = (MW-15)'(mix >>> 15);

  always_comb begin
    priority if (y > YMax) begin
      y_sat = {1'b0, {(S-1){1'b1}}};
    end else if (y < YMin) begin
      y_sat = {1'b1, {(S-1){1'b0}}};
    end else begin
      y_sat = S'(y);
    end
  end

  logic out_free;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign q_pop_o      = (state_q == ST_QUANT) && q_valid_i;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_QUANT;
      out_valid_q  <= 1'b0;
      sample_out_q <= '0;
    end else begin
      unique case (state_q)
        ST_QUANT: begin
          if (q_valid_i) begin
            state_q <= ST_RECIP;
          end
        end
        ST_RECIP: state_q <= ST_EST;
        ST_EST:   state_q <= ST_CORR;
        ST_CORR:  state_q <= ST_WET;
        ST_WET:   state_q <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_QUANT;
          end
        end
        default: state_q <= ST_QUANT;
      endcase
      // Load the next result, or drop the one just taken
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q  <= 1'b1;
        sample_out_q <= y_sat;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (state_q)
      ST_QUANT: begin
        held_q   <= held_in;
        neg_q    <= held_in[S-1];
        gated_q  <= gated;
        bypass_q <= bypass;
        q2_q     <= q2;
      end
      ST_RECIP: acc_q     <= prod_q;
      ST_EST:   est_q     <= est_d;
      ST_CORR:  crushed_q <= crushed_d;
      default: begin
      end
    endcase
  end

endmodule

>>> hdl/bit_mask_crusher_with_hold_core.sv
// Top level of the bit mask crusher with per-channel hold.
// Depends on bmc_pkg, bmc_front, bmc_fifo and bmc_back.
//
// Each accepted sample gives exactly one output sample, in order. The front
// end takes a sample and hands it to a two-entry queue; the back end then
// steps it through six states (quantize, reciprocal multiply, estimate,
// correct, wet multiply, mix), an order set by the one multiplier it shares
// between the dry gain, the 1/QMAX rescale and the wet gain. It takes a new
// sample only once it is through with the last; the queue and the output
// register let input and output stall independently. Configuration writes
// take effect at once and are meant to happen while no sample is in flight.
module bit_mask_crusher_with_hold_core #(
  parameter int QUANT_BITS  = 8,
  parameter int SAMPLE_BITS = 16,
  parameter int CHANNELS    = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          channel_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  input  logic                          cfg_we_i,
  input  logic [bmc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bmc_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic [bmc_pkg::FactorW-1:0] factor_q;
  bmc_pkg::cfg_t               cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q             <= bmc_pkg::FactorRst;
      cfg_q.keep_mask      <= bmc_pkg::KeepRst;
      cfg_q.invert_mask    <= bmc_pkg::InvertRst;
      cfg_q.dry_gain       <= bmc_pkg::DryRst;
      cfg_q.wet_gain       <= bmc_pkg::WetRst;
      cfg_q.gate_threshold <= bmc_pkg::GateRst;
    end else if (cfg_we_i) begin
      unique case (bmc_pkg::cfg_reg_e'(cfg_index_i))
        bmc_pkg::CFG_FACTOR: factor_q             <= cfg_data_i[bmc_pkg::FactorW-1:0];
        bmc_pkg::CFG_KEEP:   cfg_q.keep_mask      <= cfg_data_i[bmc_pkg::MaskW-1:0];
        bmc_pkg::CFG_INVERT: cfg_q.invert_mask    <= cfg_data_i[bmc_pkg::MaskW-1:0];
        bmc_pkg::CFG_DRY:    cfg_q.dry_gain       <= cfg_data_i[bmc_pkg::GainW-1:0];
        bmc_pkg::CFG_WET:    cfg_q.wet_gain       <= cfg_data_i[bmc_pkg::GainW-1:0];
        bmc_pkg::CFG_GATE:   cfg_q.gate_threshold <= cfg_data_i[bmc_pkg::ThrW-1:0];
        default: begin
        end
      endcase
    end
  end

  logic                       push, full, q_valid, q_pop;
  logic [2*SAMPLE_BITS-1:0]   push_data, q_data;

  bmc_front #(
    .SampleBits (SAMPLE_BITS),
    .Channels   (CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .channel_i   (channel_i),
    .sample_in_i (sample_in_i),
    .factor_i    (factor_q),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  bmc_fifo #(
    .Width (2 * SAMPLE_BITS),
    .Depth (2)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  bmc_back #(
    .QuantBits  (QUANT_BITS),
    .SampleBits (SAMPLE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_valid_i    (q_valid),
    .q_data_i     (q_data),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o)
  );

endmodule

>>> tb/tb_bit_mask_crusher_with_hold_core.sv
// Testbench for the bit mask crusher core with per-channel sample hold.
// Depends on bmc_pkg and bit_mask_crusher_with_hold_core; checks every output
// against a built-in model of hold, gate, quantize, mask and mix.
`timescale 1ns / 100ps

module tb_bit_mask_crusher_with_hold_core;

  localparam int SampleW     = 16;
  localparam int QuantW      = 8;
  localparam int QMax        = (1 << QuantW) - 1;
  localparam int FullScale   = 1 << (SampleW - 1);
  localparam int DrainCycles = 12;
  localparam int CycleLimit  = 400000;
  localparam int IdlePct     = 38;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_stall_o;
  logic                               channel_i;
  logic signed [SampleW-1:0]          sample_in_i;
  logic                               out_valid_o;
  logic                               out_stall_i;
  logic signed [SampleW-1:0]          sample_out_o;
  logic                               cfg_we_i;
  logic [bmc_pkg::CfgIdxW-1:0]        cfg_index_i;
  logic [bmc_pkg::CfgDataW-1:0]       cfg_data_i;

  bit_mask_crusher_with_hold_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .channel_i   (channel_i),
    .sample_in_i (sample_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_out_o(sample_out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Model copy of the settings and the per-channel hold state.
  logic [bmc_pkg::FactorW-1:0] factor_r;
  logic [bmc_pkg::MaskW-1:0]   keep_r;
  logic [bmc_pkg::MaskW-1:0]   invert_r;
  logic [bmc_pkg::GainW-1:0]   dry_r;
  logic [bmc_pkg::GainW-1:0]   wet_r;
  logic [bmc_pkg::ThrW-1:0]    gate_r;
  logic signed [SampleW-1:0]   held_q [2];
  logic [bmc_pkg::CountW-1:0]  hold_cnt_q [2];

  logic signed [SampleW-1:0] expected_mix_q [$];

  bit in_idle_en;
  bit out_idle_en;
  int mismatch_cnt;
  int samples_sent;
  int outputs_checked;
  int settings_used;
  int cycle_cnt;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d outputs pending", cycle_cnt,
               expected_mix_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= out_idle_en && ($urandom_range(99) < IdlePct);
  end

  task automatic report_mismatch(string what, int exp_v, int got_v);
    mismatch_cnt++;
    $display("MISMATCH %s: expected %0d, got %0d (output %0d)", what, exp_v, got_v,
             outputs_checked);
  endtask

  always @(posedge clk_i) begin : check_out
    logic signed [SampleW-1:0] exp_v;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_mix_q.size() == 0) begin
        report_mismatch("output with no sample pending", 0, int'(sample_out_o));
      end else begin
        exp_v = expected_mix_q.pop_front();
        if (sample_out_o !== exp_v) begin
          report_mismatch("sample_out", int'(exp_v), int'(sample_out_o));
        end
      end
      outputs_checked++;
    end
  end

  // Crush one held sample; the result can reach +FullScale.
  function automatic int crushed_level(logic signed [SampleW-1:0] x);
    int mag;
    int q;
    int m;
    if (keep_r == '1 && invert_r == '0) return int'(x);
    mag = (x < 0) ? -int'(x) : int'(x);
    if (mag < int'(gate_r) || mag == 0) return 0;
    q = (mag * QMax + FullScale / 2) >>> (SampleW - 1);
    q = (q & int'(keep_r)) ^ int'(invert_r);
    m = (q * FullScale + QMax / 2) / QMax;
    return (x < 0) ? -m : m;
  endfunction

  // Advance the hold state of one channel and return the mixed output.
  function automatic logic signed [SampleW-1:0] predict_mix(logic ch,
                                                            logic signed [SampleW-1:0] x);
    int     f;
    longint acc;
    longint y;
    f = (factor_r == 0) ? 1 : (factor_r > 64) ? 64 : int'(factor_r);
    if (hold_cnt_q[ch] == 0) begin
      held_q[ch]     = x;
      hold_cnt_q[ch] = bmc_pkg::CountW'(f - 1);
    end else begin
      hold_cnt_q[ch] = hold_cnt_q[ch] - 1'b1;
    end
    acc = longint'(dry_r) * longint'(x)
        + longint'(wet_r) * longint'(crushed_level(held_q[ch])) + 16384;
    y = acc >>> 15;
    if (y > FullScale - 1) y = FullScale - 1;
    if (y < -FullScale) y = -FullScale;
    return SampleW'(y);
  endfunction

  task automatic send_sample(logic ch, logic signed [SampleW-1:0] s);
    @(negedge clk_i);
    while (in_idle_en && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    channel_i   <= ch;
    sample_in_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    expected_mix_q.push_back(predict_mix(ch, s));
    samples_sent++;
  endtask

  // Hold off until every pending output has come and the pipeline is empty.
  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_mix_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(bmc_pkg::cfg_reg_e idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= bmc_pkg::CfgDataW'(val);
    unique case (idx)
      bmc_pkg::CFG_FACTOR: factor_r = bmc_pkg::FactorW'(val);
      bmc_pkg::CFG_KEEP:   keep_r   = bmc_pkg::MaskW'(val);
      bmc_pkg::CFG_INVERT: invert_r = bmc_pkg::MaskW'(val);
      bmc_pkg::CFG_DRY:    dry_r    = bmc_pkg::GainW'(val);
      bmc_pkg::CFG_WET:    wet_r    = bmc_pkg::GainW'(val);
      bmc_pkg::CFG_GATE:   gate_r   = bmc_pkg::ThrW'(val);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_settings(int unsigned fac, int unsigned keep, int unsigned inv,
                                int unsigned dry, int unsigned wet, int unsigned gate);
    write_reg(bmc_pkg::CFG_FACTOR, fac);
    write_reg(bmc_pkg::CFG_KEEP, keep);
    write_reg(bmc_pkg::CFG_INVERT, inv);
    write_reg(bmc_pkg::CFG_DRY, dry);
    write_reg(bmc_pkg::CFG_WET, wet);
    write_reg(bmc_pkg::CFG_GATE, gate);
    settings_used++;
  endtask

  function automatic logic signed [SampleW-1:0] random_sample();
    int mag;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: return SampleW'(-FullScale);
          1: return SampleW'(FullScale - 1);
          2: return SampleW'(0);
          3: return SampleW'(1);
          default: return SampleW'(-1);
        endcase
      end
      1, 2: begin
        mag = $urandom_range(0, 1200);
        return $urandom_range(1) ? SampleW'(-mag) : SampleW'(mag);
      end
      default: return SampleW'($urandom);
    endcase
  endfunction

  function automatic int unsigned random_gain();
    case ($urandom_range(5))
      0: return 0;
      1: return 32768;
      2: return 65535;
      3: return $urandom_range(0, 65535);
      default: return $urandom_range(0, 32768);
    endcase
  endfunction

  function automatic int unsigned random_mask(int unsigned common);
    case ($urandom_range(4))
      0: return common;
      1: return 8'hFF - common;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // Defaults after reset bypass the crusher: output equals input.
  task automatic test_passthrough();
    send_sample(1'b0, 16'sd0);
    send_sample(1'b1, 16'sd32767);
    send_sample(1'b0, -16'sd32768);
    send_sample(1'b1, -16'sd1);
    send_sample(1'b0, 16'sd1);
    send_sample(1'b1, 16'sd0);
    wait_drain();
  endtask

  task automatic test_crush_cases();
    // Wet only; full scale inverted into the top bit and saturated by the mix.
    write_settings(1, 8'h7F, 8'h80, 0, 32768, 328);
    send_sample(1'b0, 16'sd32767);
    send_sample(1'b1, -16'sd32768);
    send_sample(1'b0, 16'sd0);
    send_sample(1'b1, 16'sd100);
    send_sample(1'b0, -16'sd327);
    send_sample(1'b1, 16'sd328);
    send_sample(1'b0, 16'sd12345);
    wait_drain();
    write_settings(1, 8'hF0, 8'h00, 16384, 16384, 0);
    send_sample(1'b0, 16'sd5000);
    send_sample(1'b1, -16'sd5000);
    wait_drain();
    // Gains above unity drive the mix into both rails.
    write_settings(1, 8'h00, 8'hFF, 65535, 65535, 0);
    send_sample(1'b0, 16'sd30000);
    send_sample(1'b1, -16'sd30000);
    wait_drain();
  endtask

  task automatic test_hold_factor();
    write_settings(0, 8'hC3, 8'h24, 32768, 32768, 0);
    send_sample(1'b0, 16'sd20000);
    send_sample(1'b0, -16'sd7000);
    wait_drain();
    write_settings(3, 8'hC3, 8'h24, 32768, 32768, 0);
    send_sample(1'b0, 16'sd9000);
    send_sample(1'b1, -16'sd15000);
    send_sample(1'b0, 16'sd100);
    send_sample(1'b0, -16'sd2500);
    wait_drain();
    // Factor above the hold range clamps to the longest hold.
    write_settings(127, 8'hC3, 8'h24, 32768, 32768, 0);
    send_sample(1'b1, 16'sd31000);
    send_sample(1'b1, -16'sd31000);
    wait_drain();
  endtask

  task automatic test_random_phases(int phases, int per_phase);
    int unsigned fac;
    int unsigned keep;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(5))
        0: fac = 0;
        1: fac = 1;
        2: fac = $urandom_range(2, 8);
        3: fac = 64;
        4: fac = $urandom_range(65, 127);
        default: fac = $urandom_range(1, 64);
      endcase
      keep = random_mask(8'hFF);
      if (p == 0) begin
        write_settings(64, 8'h00, 8'hFF, 0, 65535, 0);
      end else if (p == 1) begin
        write_settings(127, 8'hFF, 8'h00, 65535, 32768, 32767);
      end else begin
        write_settings(fac, keep, random_mask(8'h00), random_gain(), random_gain(),
                       $urandom_range(3) == 0 ? $urandom_range(0, 32767)
                                             : $urandom_range(0, 1500));
      end
      // Keep one phase free of gaps and stalls on both sides.
      in_idle_en  = (p != 4);
      out_idle_en = (p != 4);
      for (int n = 0; n < per_phase; n++) begin
        if (p == 2 && n == per_phase / 2) wait_drain();
        send_sample(1'($urandom_range(1)), random_sample());
      end
      wait_drain();
    end
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    channel_i   = 1'b0;
    sample_in_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = bmc_pkg::CFG_FACTOR;
    cfg_data_i  = '0;
    factor_r    = bmc_pkg::FactorRst;
    keep_r      = bmc_pkg::KeepRst;
    invert_r    = bmc_pkg::InvertRst;
    dry_r       = bmc_pkg::DryRst;
    wet_r       = bmc_pkg::WetRst;
    gate_r      = bmc_pkg::GateRst;
    for (int c = 0; c < 2; c++) begin
      held_q[c]     = '0;
      hold_cnt_q[c] = '0;
    end
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_passthrough();
    test_crush_cases();
    test_hold_factor();
    test_random_phases(14, 125);

    wait_drain();
    $display("Checked %0d outputs for %0d samples over %0d register settings,",
             outputs_checked, samples_sent, settings_used);
    $display("with hold factors 0..127, gating, masking, inversion and saturation.");
    if (mismatch_cnt == 0 && expected_mix_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
